### rtl/lps_pkg.sv
// Shared types, constants and register codes of the line position steering block.
package lps_pkg;

    localparam int NUM_CH      = 6;
    localparam int CH_W        = 3;
    localparam int RAW_W       = 10;
    localparam int SAMPLE_BITS = 10;
    // widest sample width the converter may use
    localparam int EXT_W       = 16;
    localparam int THR_W       = 10;
    localparam int POS_W       = 6;
    localparam int DUTY_W      = 8;
    localparam int TOTAL_W     = 8;
    localparam int CNT_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THR0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THR4   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THR5   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TURN   = 3'd7;

    localparam logic [THR_W-1:0] THR0_RST = 10'd250;
    localparam logic [THR_W-1:0] THR1_RST = 10'd350;
    localparam logic [THR_W-1:0] THR2_RST = 10'd350;
    localparam logic [THR_W-1:0] THR3_RST = 10'd300;
    localparam logic [THR_W-1:0] THR4_RST = 10'd350;
    localparam logic [THR_W-1:0] THR5_RST = 10'd70;
    localparam logic [POS_W-1:0] CENTER_RST = 6'd35;
    localparam logic [DUTY_W-1:0] TURN_RST  = 8'd150;

    // direction codes
    localparam logic [1:0] DIR_FWD   = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_BACK  = 2'd3;

    // motor bridge patterns
    localparam logic [3:0] PAT_FWD   = 4'b1010;
    localparam logic [3:0] PAT_LEFT  = 4'b1000;
    localparam logic [3:0] PAT_RIGHT = 4'b0010;
    localparam logic [3:0] PAT_BACK  = 4'b0101;

    localparam logic [DUTY_W-1:0] DUTY_FWD  = 8'd255;
    localparam logic [DUTY_W-1:0] DUTY_BACK = 8'd200;

    localparam logic [TOTAL_W-1:0] CH_WEIGHT [NUM_CH] =
        '{8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60};

    typedef logic [THR_W-1:0] t_thr_arr [NUM_CH];

    typedef struct packed {
        logic              valid;
        logic [NUM_CH-1:0] flags;
    } t_flag_msg;

    typedef struct packed {
        logic [1:0]        direction;
        logic [3:0]        drive_pattern;
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [POS_W-1:0]  position;
    } t_result;

endpackage

### rtl/lps_front.sv
// Sample intake: inverts each sample, flags a line per channel and posts each finished round.
module lps_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [lps_pkg::RAW_W-1:0] i_raw_sample,
    input  lps_pkg::t_thr_arr i_thr,
    input  logic              i_q_full,
    output lps_pkg::t_flag_msg o_push
);
    import lps_pkg::*;

    logic [CH_W-1:0]        r_ch, n_ch;
    logic [NUM_CH-1:0]      r_flags, n_flags;
    logic [CH_W-1:0]        ch_eff;
    logic                   last;
    logic                   acc;
    logic [EXT_W-1:0]       raw_ext;
    logic [SAMPLE_BITS-1:0] inv;
    logic                   hit;

    // an out-of-range index counts as channel 0
    assign ch_eff = (r_ch < CH_W'(NUM_CH)) ? r_ch : '0;
    assign last   = (ch_eff == CH_W'(NUM_CH - 1));

    // hold the last sample of a round until the queue has room
    assign o_in_stall = last && i_q_full;
    assign acc        = i_in_valid && !o_in_stall;

    assign raw_ext = EXT_W'(i_raw_sample);
    assign inv     = ~raw_ext[SAMPLE_BITS-1:0];
    assign hit     = EXT_W'(inv) <= EXT_W'(i_thr[ch_eff]);

    always_comb begin
        n_flags         = r_flags;
        n_flags[ch_eff] = hit;
        n_ch            = last ? '0 : ch_eff + CH_W'(1);
    end

    assign o_push.valid = acc && last;
    assign o_push.flags = n_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch    <= '0;
            r_flags <= '0;
        end else if (acc) begin
            r_ch    <= n_ch;
            r_flags <= n_flags;
        end
    end

endmodule

### rtl/lps_queue.sv
// Short queue of finished flag rounds between intake and steering.
module lps_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lps_pkg::t_flag_msg i_push,
    output logic               o_full,
    input  logic               i_pop,
    output lps_pkg::t_flag_msg o_head
);
    import lps_pkg::*;

    logic [NUM_CH-1:0] r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt, n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full       = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.flags = r_mem[r_rp];

    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + (QPTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
        end
    end

endmodule

### rtl/lps_back.sv
// Steering: weighted average by bit-serial division, drive decision and output register.
module lps_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lps_pkg::t_flag_msg i_head,
    output logic               o_pop,
    input  logic [lps_pkg::POS_W-1:0]  i_center,
    input  logic [lps_pkg::DUTY_W-1:0] i_turn_duty,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lps_pkg::t_result   o_result
);
    import lps_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]         r_state;
    logic [TOTAL_W-1:0] r_dvd;
    logic [CNT_W-1:0]   r_dvs;
    logic [CNT_W-1:0]   r_rem;
    logic [2:0]         r_step;
    logic               r_none;
    logic               r_out_valid;
    t_result            r_result, n_result;

    logic [TOTAL_W-1:0] total;
    logic [CNT_W-1:0]   count;
    logic [CNT_W:0]     rem_sh;
    logic               ge;
    logic [CNT_W:0]     rem_sub;
    logic [POS_W-1:0]   pos;
    logic               out_free;

    always_comb begin
        total = '0;
        count = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            if (i_head.flags[i]) begin
                total = total + CH_WEIGHT[i];
                count = count + CNT_W'(1);
            end
        end
    end

    // one quotient bit per cycle, dividend shifts left and collects the quotient
    assign rem_sh  = {r_rem, r_dvd[TOTAL_W-1]};
    assign ge      = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = ge ? rem_sh - {1'b0, r_dvs} : rem_sh;

    assign pos      = r_dvd[POS_W-1:0];
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == ST_IDLE) && i_head.valid;

    always_comb begin
        n_result.position = pos;
        if (r_none) begin
            n_result.direction     = DIR_BACK;
            n_result.drive_pattern = PAT_BACK;
            n_result.duty_a        = DUTY_BACK;
            n_result.duty_b        = DUTY_BACK;
            n_result.position      = '0;
        end else if (pos == i_center) begin
            n_result.direction     = DIR_FWD;
            n_result.drive_pattern = PAT_FWD;
            n_result.duty_a        = DUTY_FWD;
            n_result.duty_b        = DUTY_FWD;
        end else if (pos < i_center) begin
            n_result.direction     = DIR_LEFT;
            n_result.drive_pattern = PAT_LEFT;
            n_result.duty_a        = i_turn_duty;
            n_result.duty_b        = i_turn_duty;
        end else begin
            n_result.direction     = DIR_RIGHT;
            n_result.drive_pattern = PAT_RIGHT;
            n_result.duty_a        = i_turn_duty;
            n_result.duty_b        = i_turn_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    r_dvd  <= total;
                    r_dvs  <= count;
                    r_rem  <= '0;
                    r_step <= '0;
                    r_none <= (count == '0);
                end
            end
            ST_DIV: begin
                r_dvd  <= {r_dvd[TOTAL_W-2:0], ge};
                r_rem  <= rem_sub[CNT_W-1:0];
                r_step <= r_step + 3'd1;
            end
            ST_DONE: begin
                if (out_free) begin
                    r_result <= n_result;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_head.valid) begin
                        r_state <= (count == '0) ? ST_DONE : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_step == 3'd7) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

### rtl/line_position_steering_top.sv
// Top level of the line position steering block: register file and the front/queue/back chain.
//
//  channel  direction  handshake              payload
//  in       input      i_in_valid/o_in_stall  i_raw_sample
//  out      output     o_out_valid/i_out_stall o_direction, o_drive_pattern, o_duty_a,
//                                             o_duty_b, o_position
//  config   input      i_cfg_we               i_cfg_idx, i_cfg_data
//
// Samples are taken one a cycle unless stalled; the sixth of a round posts its flags
// to a two-entry queue. The steering part takes one round at a time: it loads the round,
// runs the bit-serial divide (skipped when no channel is flagged), then loads the output
// register once the output is free. The last sample of a round stalls while the queue is full.
// Synchronous active-low reset restores the register defaults and starts at channel 0.
module line_position_steering_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [9:0]  i_raw_sample,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_direction,
    output logic [3:0]  o_drive_pattern,
    output logic [7:0]  o_duty_a,
    output logic [7:0]  o_duty_b,
    output logic [5:0]  o_position,
    input  logic        i_cfg_we,
    input  logic [lps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lps_pkg::*;

    t_thr_arr          r_thr;
    logic [POS_W-1:0]  r_center;
    logic [DUTY_W-1:0] r_turn;

    t_flag_msg push;
    t_flag_msg head;
    logic      q_full;
    logic      pop;
    t_result   result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr[0] <= THR0_RST;
            r_thr[1] <= THR1_RST;
            r_thr[2] <= THR2_RST;
            r_thr[3] <= THR3_RST;
            r_thr[4] <= THR4_RST;
            r_thr[5] <= THR5_RST;
            r_center <= CENTER_RST;
            r_turn   <= TURN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_THR0:   r_thr[0] <= i_cfg_data[THR_W-1:0];
                REG_THR1:   r_thr[1] <= i_cfg_data[THR_W-1:0];
                REG_THR2:   r_thr[2] <= i_cfg_data[THR_W-1:0];
                REG_THR3:   r_thr[3] <= i_cfg_data[THR_W-1:0];
                REG_THR4:   r_thr[4] <= i_cfg_data[THR_W-1:0];
                REG_THR5:   r_thr[5] <= i_cfg_data[THR_W-1:0];
                REG_CENTER: r_center <= i_cfg_data[POS_W-1:0];
                REG_TURN:   r_turn   <= i_cfg_data[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lps_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_raw_sample (i_raw_sample),
        .i_thr        (r_thr),
        .i_q_full     (q_full),
        .o_push       (push)
    );

    lps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head)
    );

    lps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_center    (r_center),
        .i_turn_duty (r_turn),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_direction     = result.direction;
    assign o_drive_pattern = result.drive_pattern;
    assign o_duty_a        = result.duty_a;
    assign o_duty_b        = result.duty_b;
    assign o_position      = result.position;

endmodule
